/* rtl/cieu_pkg.sv */
// cieu_pkg: operation codes and constants for the integer execute unit
// no dependencies
`default_nettype none

package cieu_pkg;

	localparam int NUM_REGS_DEF = 16;
	localparam int XLEN = 32;

	localparam logic [31:0] MASK_HI_BYTES = 32'hFF00FF00;
	localparam logic [31:0] MASK_LO_BYTES = 32'h00FF00FF;

	typedef enum logic [6:0] {
		OP_MOV_I, OP_MOV_DRI, OP_ADD_I, OP_ADD_DRI, OP_ADD_RDR, OP_MOV, OP_ADD, OP_SUB,
		OP_SUB_RDR, OP_ADC, OP_SBB, OP_TST, OP_TST_I, OP_AND, OP_AND_I, OP_AND_DR,
		OP_OR, OP_OR_DR, OP_XOR, OP_XOR_DR, OP_MULS, OP_MULU, OP_CMPEQ, OP_CMPHI,
		OP_CMPGT, OP_CMPHS, OP_CMPGE, OP_CMPEQ_I, OP_CMPGT_I, OP_CMPGE_I, OP_LDIZ,
		OP_LDIN, OP_LDSH8, OP_LDSH16, OP_LDSH12, OP_LDSH20, OP_LDIZ12, OP_LDIN12,
		OP_LEA_I1, OP_LEA_I2, OP_LEA_I4, OP_LEA_D1, OP_LEA_D2, OP_LEA_D4, OP_LEA_D8,
		OP_PCA1, OP_PCA2, OP_PCA4, OP_PCA_I1, OP_PCA_I2, OP_NOP, OP_CLRT, OP_SETT,
		OP_CLRS, OP_SETS, OP_NOTT, OP_NOTS, OP_CMPPL, OP_CMPPZ, OP_EXTUB, OP_EXTUW,
		OP_EXTSB, OP_EXTSW, OP_SHLI, OP_SHRI, OP_SARI, OP_NOT, OP_NEG, OP_NEGC,
		OP_ROTL, OP_ROTR, OP_ROTCL, OP_ROTCR, OP_SHL1, OP_SHR1, OP_SAR1, OP_MOVT,
		OP_SWAPB, OP_SWAPW, OP_SHAD, OP_SHLD
	} op_t;

endpackage

`default_nettype wire

/* rtl/cpu_integer_execute_unit.sv */
// the result is registered behind an input stage (input stage, then result register)
// throughput: one instruction per cycle unless a stalled result holds the input; the alu pass sits between the input
// stage and the result register, register reads are bypassed from the instruction ahead
// reset: asynchronous, clears the register file valid bits, T, S, DR and the
// multiply registers, so every register reads as zero after reset
// cpu_integer_execute_unit: top level, uses cieu_pkg
`default_nettype none

module cpu_integer_execute_unit #(
	parameter int NUM_REGS = cieu_pkg::NUM_REGS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [6:0]  op,
	input  wire logic [3:0]  dst_reg,
	input  wire logic [3:0]  src_reg,
	input  wire logic signed [31:0] immediate,
	input  wire logic [31:0] instr_addr,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             dest_valid,
	output logic [3:0]       dest_index,
	output logic [31:0]      dest_value,
	output logic             t_flag,
	output logic             s_flag,
	output logic [31:0]      ext_value,
	output logic [31:0]      mul_low,
	output logic [31:0]      mul_high
);
	import cieu_pkg::*;

	localparam int IW = $clog2(NUM_REGS);

	logic [31:0] regs [NUM_REGS];
	logic [NUM_REGS-1:0] rvld_q;

	logic        vld_s1;
	logic [6:0]  op_s1;
	logic [3:0]  rn_s1;
	logic        rnok_s1;
	logic [31:0] araw_s1, braw_s1, fwd_s1, imm_s1, pc_s1;
	logic        aok_s1, bok_s1, bypa_s1, bypb_s1;

	logic        t_q, s_q;
	logic [31:0] dr_q, pl_q, ph_q;
	logic        ovld_q, dvld_q;
	logic [3:0]  didx_q;
	logic [31:0] dval_q;

	logic        s1_fire, accept, wr_eff;
	logic [5:0]  dx, sx;
	logic        d_in, s_in;
	logic [IW-1:0] didx, sidx, widx;

	logic [31:0] a, b, res, dr_n, pl_n, ph_n;
	logic        wr, t_n, s_n, pwr;
	logic [32:0] wide;
	logic signed [32:0] ma, mb;
	logic signed [65:0] mprod;
	logic [7:0]  cnt, ncnt;
	op_t         opc;

	assign s1_fire = vld_s1 && (!ovld_q || out_ready);
	assign in_ready = !vld_s1 || s1_fire;
	assign accept = in_valid && in_ready;

	assign dx = 6'(dst_reg);
	assign sx = 6'(src_reg);
	assign d_in = dx < 6'(NUM_REGS);
	assign s_in = sx < 6'(NUM_REGS);
	assign didx = dx[IW-1:0];
	assign sidx = sx[IW-1:0];
	assign widx = IW'(rn_s1);
	assign wr_eff = wr && rnok_s1;

	// operands, with the instruction ahead forwarded
	assign a = bypa_s1 ? fwd_s1 : (aok_s1 ? araw_s1 : 32'd0);
	assign b = bypb_s1 ? fwd_s1 : (bok_s1 ? braw_s1 : 32'd0);

	assign ma = {(opc == OP_MULS) && a[31], a};
	assign mb = {(opc == OP_MULS) && b[31], b};
	assign mprod = ma * mb;

	always_comb begin
		opc = op_t'(op_s1);
		res = 32'd0;
		wr = 1'b0;
		t_n = t_q;
		s_n = s_q;
		dr_n = dr_q;
		pwr = 1'b0;
		wide = 33'd0;
		cnt = b[7:0];
		ncnt = 8'd0 - cnt;
		case (opc)
			OP_MOV_I: begin res = imm_s1; wr = 1'b1; end
			OP_MOV_DRI: begin res = (dr_q << 4) + imm_s1; wr = 1'b1; end
			OP_ADD_I: begin res = a + imm_s1; wr = 1'b1; end
			OP_ADD_DRI: begin res = a + (dr_q << 4) + imm_s1; wr = 1'b1; end
			OP_ADD_RDR, OP_LEA_D1: begin res = b + dr_q; wr = 1'b1; end
			OP_MOV: begin res = b; wr = 1'b1; end
			OP_ADD: begin res = a + b; wr = 1'b1; end
			OP_SUB: begin res = a - b; wr = 1'b1; end
			OP_SUB_RDR: begin res = b - dr_q; wr = 1'b1; end
			OP_ADC: begin
				wide = {1'b0, a} + {1'b0, b} + 33'(t_q);
				res = wide[31:0]; t_n = wide[32]; wr = 1'b1;
			end
			OP_SBB: begin
				wide = {1'b0, a} - {1'b0, b} - 33'(t_q);
				res = wide[31:0]; t_n = wide[32]; wr = 1'b1;
			end
			OP_TST: t_n = (a & b) == 32'd0;
			OP_TST_I: t_n = (a & imm_s1) == 32'd0;
			OP_AND: begin res = a & b; wr = 1'b1; end
			OP_AND_I: begin res = a & imm_s1; wr = 1'b1; end
			OP_AND_DR: begin res = b & dr_q; wr = 1'b1; end
			OP_OR: begin res = a | b; wr = 1'b1; end
			OP_OR_DR: begin res = b | dr_q; wr = 1'b1; end
			OP_XOR: begin res = a ^ b; wr = 1'b1; end
			OP_XOR_DR: begin res = b ^ dr_q; wr = 1'b1; end
			OP_MULS, OP_MULU: pwr = 1'b1;
			OP_CMPEQ: t_n = a == b;
			OP_CMPHI: t_n = a > b;
			OP_CMPGT: t_n = $signed(a) > $signed(b);
			OP_CMPHS: t_n = a >= b;
			OP_CMPGE: t_n = $signed(a) >= $signed(b);
			OP_CMPEQ_I: t_n = a == imm_s1;
			OP_CMPGT_I: t_n = $signed(a) > $signed(imm_s1);
			OP_CMPGE_I: t_n = $signed(a) >= $signed(imm_s1);
			OP_LDIZ: dr_n = {24'd0, imm_s1[7:0]};
			OP_LDIN: dr_n = {24'hFFFFFF, imm_s1[7:0]};
			OP_LDSH8: dr_n = {dr_q[23:0], imm_s1[7:0]};
			OP_LDSH16: dr_n = {dr_q[15:0], imm_s1[15:0]};
			OP_LDSH12: dr_n = {dr_q[19:0], imm_s1[11:0]};
			OP_LDSH20: dr_n = {dr_q[11:0], imm_s1[19:0]};
			OP_LDIZ12: dr_n = {20'd0, imm_s1[11:0]};
			OP_LDIN12: dr_n = {20'hFFFFF, imm_s1[11:0]};
			OP_LEA_I1: begin res = b + imm_s1; wr = 1'b1; end
			OP_LEA_I2: begin res = b + (imm_s1 << 1); wr = 1'b1; end
			OP_LEA_I4: begin res = b + (imm_s1 << 2); wr = 1'b1; end
			OP_LEA_D2: begin res = b + (dr_q << 1); wr = 1'b1; end
			OP_LEA_D4: begin res = b + (dr_q << 2); wr = 1'b1; end
			OP_LEA_D8: begin res = b + (dr_q << 3); wr = 1'b1; end
			OP_PCA1: begin res = pc_s1 + 32'd2 + dr_q; wr = 1'b1; end
			OP_PCA2: begin res = pc_s1 + 32'd2 + (dr_q << 1); wr = 1'b1; end
			OP_PCA4: begin res = pc_s1 + 32'd2 + (dr_q << 2); wr = 1'b1; end
			OP_PCA_I1: begin res = pc_s1 + 32'd2 + (dr_q << 4) + imm_s1; wr = 1'b1; end
			OP_PCA_I2: begin
				res = pc_s1 + 32'd2 + (dr_q << 5) + (imm_s1 << 1); wr = 1'b1;
			end
			OP_NOP: ;
			OP_CLRT: t_n = 1'b0;
			OP_SETT: t_n = 1'b1;
			OP_CLRS: s_n = 1'b0;
			OP_SETS: s_n = 1'b1;
			OP_NOTT: t_n = !t_q;
			OP_NOTS: s_n = !s_q;
			OP_CMPPL: t_n = $signed(a) > 0;
			OP_CMPPZ: t_n = !a[31];
			OP_EXTUB: begin res = {24'd0, a[7:0]}; wr = 1'b1; end
			OP_EXTUW: begin res = {16'd0, a[15:0]}; wr = 1'b1; end
			OP_EXTSB: begin res = {{24{a[7]}}, a[7:0]}; wr = 1'b1; end
			OP_EXTSW: begin res = {{16{a[15]}}, a[15:0]}; wr = 1'b1; end
			OP_SHLI: begin res = a << imm_s1[4:0]; wr = 1'b1; end
			OP_SHRI: begin res = a >> imm_s1[4:0]; wr = 1'b1; end
			OP_SARI: begin res = 32'($signed(a) >>> imm_s1[4:0]); wr = 1'b1; end
			OP_NOT: begin res = ~a; wr = 1'b1; end
			OP_NEG: begin res = 32'd0 - a; wr = 1'b1; end
			OP_NEGC: begin res = 32'd0 - a - 32'(t_q); wr = 1'b1; end
			OP_ROTL: begin res = {a[30:0], a[31]}; wr = 1'b1; end
			OP_ROTR: begin res = {a[0], a[31:1]}; wr = 1'b1; end
			OP_ROTCL: begin res = {a[30:0], t_q}; t_n = a[31]; wr = 1'b1; end
			OP_ROTCR: begin res = {t_q, a[31:1]}; t_n = a[0]; wr = 1'b1; end
			OP_SHL1: begin res = {a[30:0], 1'b0}; t_n = a[31]; wr = 1'b1; end
			OP_SHR1: begin res = {1'b0, a[31:1]}; t_n = a[0]; wr = 1'b1; end
			OP_SAR1: begin res = {a[31], a[31:1]}; t_n = a[31]; wr = 1'b1; end
			OP_MOVT: begin res = 32'(t_q); wr = 1'b1; end
			OP_SWAPB: begin
				res = ((a & MASK_HI_BYTES) >> 8) | ((a & MASK_LO_BYTES) << 8);
				wr = 1'b1;
			end
			OP_SWAPW: begin res = {a[15:0], a[31:16]}; wr = 1'b1; end
			OP_SHAD, OP_SHLD: begin
				wr = 1'b1;
				if (!cnt[7])
					res = a << cnt[4:0];
				else if (opc == OP_SHAD)
					res = 32'($signed(a) >>> ncnt[4:0]);
				else
					res = a >> ncnt[4:0];
			end
			default: ;
		endcase
	end

	assign pl_n = pwr ? mprod[31:0] : pl_q;
	assign ph_n = pwr ? mprod[63:32] : ph_q;

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			ovld_q <= 1'b0;
			rvld_q <= '0;
			t_q <= 1'b0;
			s_q <= 1'b0;
			dr_q <= 32'd0;
			pl_q <= 32'd0;
			ph_q <= 32'd0;
		end else begin
			if (in_ready)
				vld_s1 <= in_valid;
			if (s1_fire)
				ovld_q <= 1'b1;
			else if (out_ready)
				ovld_q <= 1'b0;
			if (s1_fire) begin
				t_q <= t_n;
				s_q <= s_n;
				dr_q <= dr_n;
				pl_q <= pl_n;
				ph_q <= ph_n;
				if (wr_eff)
					rvld_q[widx] <= 1'b1;
			end
		end
	end

	// register file and payload registers
	always_ff @(posedge clk) begin
		if (s1_fire && wr_eff)
			regs[widx] <= res;
		if (accept) begin
			op_s1 <= op;
			rn_s1 <= dst_reg;
			rnok_s1 <= d_in;
			imm_s1 <= immediate;
			pc_s1 <= instr_addr;
			araw_s1 <= regs[didx];
			braw_s1 <= regs[sidx];
			aok_s1 <= d_in && rvld_q[didx];
			bok_s1 <= s_in && rvld_q[sidx];
			bypa_s1 <= s1_fire && wr_eff && (rn_s1 == dst_reg);
			bypb_s1 <= s1_fire && wr_eff && (rn_s1 == src_reg);
			fwd_s1 <= res;
		end
		if (s1_fire) begin
			dvld_q <= wr_eff;
			didx_q <= wr_eff ? rn_s1 : 4'd0;
			dval_q <= wr_eff ? res : 32'd0;
		end
	end

	// status and special registers only change when a new result is loaded
	assign out_valid = ovld_q;
	assign dest_valid = dvld_q;
	assign dest_index = didx_q;
	assign dest_value = dval_q;
	assign t_flag = t_q;
	assign s_flag = s_q;
	assign ext_value = dr_q;
	assign mul_low = pl_q;
	assign mul_high = ph_q;

endmodule

`default_nettype wire

/* rtl/cieu_checker.sv */
// cieu_props: port-level checks for the integer execute unit, with its bind
// depends on cpu_integer_execute_unit ports only
`default_nettype none

module cieu_props (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        dest_valid,
	input wire logic [3:0]  dest_index,
	input wire logic [31:0] dest_value,
	input wire logic        t_flag,
	input wire logic [31:0] ext_value,
	input wire logic [31:0] mul_low
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !dest_valid |-> dest_index == 4'd0 && dest_value == 32'd0)
		else $error("dest fields not zero without a register write");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(t_flag) && $stable(ext_value) && $stable(mul_low))
		else $error("state changed while result stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty result register");

endmodule

bind cpu_integer_execute_unit cieu_props u_cieu_props (.*);

`default_nettype wire
